@@ hw/rtl/hkv_pkg.sv @@
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared types and constants for the hashed key-value table.
// ----------------------------------------------------------------------------
`default_nettype none

package hkv_pkg;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;

  // One stored way: valid mark, key, value (valid on top)
  localparam int SLOT_W = 1 + KEY_W + VAL_W;

  // Default table geometry
  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Remainder unit: key bits consumed per cycle, and digit steps per key
  localparam int DIGIT_W   = 8;
  localparam int DIV_STEPS = KEY_W / DIGIT_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_SET = 2'd0;
  localparam logic [FUNC_W-1:0] OP_GET = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DEL = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } hkv_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
  } hkv_rsp_t;

  localparam int REQ_W = $bits(hkv_req_t);

endpackage

`default_nettype wire

@@ hw/rtl/hkv_ram.sv @@
// ----------------------------------------------------------------------------
// hkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hkv_front.sv @@
// ----------------------------------------------------------------------------
// hkv_front
// Accepts requests, reduces the key to its bucket index and hands the
// request on to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_front #(
  parameter int BUCKETS = hkv_pkg::BUCKETS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clearing,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire hkv_pkg::hkv_req_t          req,
  output logic                            push,
  output logic [$clog2(BUCKETS)+hkv_pkg::REQ_W-1:0] push_data,
  input  wire logic                       q_full
);

  import hkv_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [BW:0] BK = (BW+1)'(BUCKETS);
  localparam int CW = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {FREE, DIVIDE, PUSH} state_t;

  state_t         state;
  hkv_req_t       cur;
  logic [KEY_W-1:0] shreg;
  logic [BW-1:0]  rem;
  logic [BW-1:0]  rem_next;
  logic [CW-1:0]  cnt;
  logic           accept;

  assign req_stall = (state != FREE) || clearing;
  assign accept    = req_valid && !req_stall;
  assign push      = (state == PUSH) && !q_full;
  assign push_data = {rem, cur};

  // One remainder digit: per key bit, shift it in, subtract the bucket count once
  always_comb begin
    logic [BW:0] t;
    rem_next = rem;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {rem_next, shreg[KEY_W-1-i]};
      if (t >= BK) begin
        t = t - BK;
      end
      rem_next = t[BW-1:0];
    end
  end

  // Request staging and bucket sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FREE;
    end else begin
      case (state)
        FREE: begin
          if (accept) begin
            cur   <= req;
            shreg <= req.key;
            cnt   <= '0;
            if (IS_POW2) begin
              rem   <= req.key[BW-1:0];
              state <= PUSH;
            end else begin
              rem   <= '0;
              state <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          rem   <= rem_next;
          shreg <= shreg << DIGIT_W;
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(DIV_STEPS - 1)) begin
            state <= PUSH;
          end
        end
        PUSH: begin
          if (!q_full) begin
            state <= FREE;
          end
        end
        default: state <= FREE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hkv_queue.sv @@
// ----------------------------------------------------------------------------
// hkv_queue
// Small FIFO that decouples the request front from the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hkv_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  assign full     = count == (PW+1)'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hkv_back.sv @@
// ----------------------------------------------------------------------------
// hkv_back
// Table back end: reads a bucket row, compares all ways, writes a changed
// row back and registers the response. Clears every valid mark after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_back #(
  parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
  parameter int WAYS    = hkv_pkg::WAYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  output logic                       clearing,
  input  wire logic                  q_empty,
  input  wire logic [$clog2(BUCKETS)+hkv_pkg::REQ_W-1:0] q_data,
  output logic                       q_pop,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output hkv_pkg::hkv_rsp_t          rsp
);

  import hkv_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DW = WAYS * SLOT_W;

  typedef enum logic [1:0] {CLEAR, IDLE, EVAL} state_t;

  state_t         state;
  logic [BW-1:0]  clr_addr;
  hkv_req_t       cur;
  logic [BW-1:0]  cur_bucket;

  hkv_req_t       q_req;
  logic [BW-1:0]  q_bucket;

  logic           ram_we;
  logic [BW-1:0]  ram_waddr;
  logic [DW-1:0]  ram_wdata;
  logic [DW-1:0]  row;
  logic [DW-1:0]  new_row;

  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] free;
  logic            hit_any;
  logic            free_any;
  logic [WW-1:0]   hit_way;
  logic [WW-1:0]   free_way;
  logic [WW-1:0]   set_way;
  logic            row_we;
  hkv_rsp_t        result;
  logic            out_free;

  assign {q_bucket, q_req} = q_data;
  assign clearing = state == CLEAR;
  assign out_free = !rsp_valid || !rsp_stall;
  assign q_pop    = (state == IDLE) && !q_empty;

  // Bucket rows: WAYS slots of {valid, key, value}
  hkv_ram #(
    .WIDTH (DW),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_bucket),
    .rdata (row)
  );

  assign ram_we    = clearing || ((state == EVAL) && out_free && row_we);
  assign ram_waddr = clearing ? clr_addr : cur_bucket;
  assign ram_wdata = clearing ? '0 : new_row;

  // Parallel way compare, lowest way wins
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = row[w*SLOT_W + SLOT_W - 1] && (row[w*SLOT_W + VAL_W +: KEY_W] == cur.key);
      free[w] = !row[w*SLOT_W + SLOT_W - 1];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
      if (free[w]) begin
        free_any = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  // Operation decode, row update and response
  always_comb begin
    set_way           = hit_any ? hit_way : free_way;
    row_we            = 1'b0;
    new_row           = row;
    result.status     = ST_MISSING;
    result.read_value = '0;
    case (cur.func)
      OP_SET: begin
        if (hit_any || free_any) begin
          row_we        = 1'b1;
          result.status = ST_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == set_way) begin
              new_row[w*SLOT_W +: SLOT_W] = {1'b1, cur.key, cur.value};
            end
          end
        end else begin
          result.status = ST_FULL;
        end
      end
      OP_GET: begin
        if (hit_any) begin
          result.status = ST_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == hit_way) begin
              result.read_value = row[w*SLOT_W +: VAL_W];
            end
          end
        end
      end
      OP_DEL: begin
        if (hit_any) begin
          row_we        = 1'b1;
          result.status = ST_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == hit_way) begin
              new_row[w*SLOT_W + SLOT_W - 1] = 1'b0;
            end
          end
        end
      end
      default: begin
        result.status = ST_MISSING;
      end
    endcase
  end

  // Sequencer: clearing pass, row read, evaluate and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Response valid: set on a finished request, cleared once taken
      if ((state == EVAL) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(BUCKETS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (!q_empty) begin
            cur        <= q_req;
            cur_bucket <= q_bucket;
            state      <= EVAL;
          end
        end
        EVAL: begin
          if (out_free) begin
            rsp   <= result;
            state <= IDLE;
          end
        end
        default: state <= CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hashed_key_value_table.sv @@
// Flow: the front takes the bucket index from the low key bits when BUCKETS is
//   a power of two, else from the key remainder (8 key bits a cycle), then
//   queues the request; it accepts no new one until that push is done. The back
//   end reads the bucket row, then writes it back before it pops the next.
// Reset: synchronous; a clearing pass over all BUCKETS rows wipes all valid marks,
//   with req_stall held high until it ends.
// ----------------------------------------------------------------------------
// hashed_key_value_table
// Set, get and delete of 64-bit keys in a bucketed, multi-way table.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_key_value_table #(
  parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
  parameter int WAYS    = hkv_pkg::WAYS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire hkv_pkg::hkv_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output hkv_pkg::hkv_rsp_t      rsp
);

  import hkv_pkg::*;

  localparam int QW = $clog2(BUCKETS) + REQ_W;

  logic          clearing;
  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_data;
  logic          q_empty;

  // Request intake and bucket index
  hkv_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Command queue
  hkv_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Table access and response
  hkv_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hkv_checker.sv @@
// ----------------------------------------------------------------------------
// hkv_checker
// Port-level checks for the hashed key-value table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_stall,
  input wire hkv_pkg::hkv_req_t req,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire hkv_pkg::hkv_rsp_t rsp
);

  import hkv_pkg::*;

  // Right after reset the request path is closed (clearing pass) and no response is out
  a_reset_state: assert property (@(posedge clk) rst |=> req_stall && !rsp_valid)
    else $error("request path open or response valid right after reset");

  // A stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != ST_UNUSED)
    else $error("unused status code");

  // Only a found entry returns a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
    else $error("nonzero value on failed request");

endmodule

bind hashed_key_value_table hkv_checker u_hkv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

@@ test/tb_hashed_key_value_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_table
// Drives set, get and delete requests into the key-value table and checks
// every response against a shadow copy of the buckets. A short directed list
// covers empty, full and overwrite cases. Random traffic then works a few hot
// buckets so that hits, misses and full buckets all occur. Both handshakes
// are throttled at random.
// ----------------------------------------------------------------------------

module tb_hashed_key_value_table;
  import hkv_pkg::*;

  localparam int BKT_W = $clog2(BUCKETS_DEF);
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_REQS = 450;
  localparam int POOL_MAX = 40;

  // Shadow of the bucket table plus the responses still owed by the block
  class hkv_shadow_table;
    bit   [WAYS_DEF-1:0] live [BUCKETS_DEF];
    logic [KEY_W-1:0]    slot_key [BUCKETS_DEF][WAYS_DEF];
    logic [VAL_W-1:0]    slot_val [BUCKETS_DEF][WAYS_DEF];
    hkv_rsp_t            owed [$];
    int mismatches;
    int n_stored, n_full, n_found, n_missing, n_checked;

    // lowest live way holding this key, -1 if none
    function int hit_way(int unsigned b, logic [KEY_W-1:0] k);
      for (int w = 0; w < WAYS_DEF; w++)
        if (live[b][w] && slot_key[b][w] == k) return w;
      return -1;
    endfunction

    function int free_way(int unsigned b);
      for (int w = 0; w < WAYS_DEF; w++)
        if (!live[b][w]) return w;
      return -1;
    endfunction

    function void apply_request(hkv_req_t r);
      int unsigned b;
      int w;
      hkv_rsp_t e;
      b = int'(r.key % 64'(BUCKETS_DEF));
      w = hit_way(b, r.key);
      e.status = ST_MISSING;
      e.read_value = '0;
      case (r.func)
        OP_SET: begin
          if (w < 0) w = free_way(b);
          if (w < 0) begin
            e.status = ST_FULL;
            n_full++;
          end else begin
            slot_key[b][w] = r.key;
            slot_val[b][w] = r.value;
            live[b][w] = 1'b1;
            e.status = ST_OK;
            n_stored++;
          end
        end
        OP_GET: begin
          if (w >= 0) begin
            e.status = ST_OK;
            e.read_value = slot_val[b][w];
            n_found++;
          end
        end
        OP_DEL: begin
          if (w >= 0) begin
            live[b][w] = 1'b0;
            e.status = ST_OK;
          end
        end
        default: ;
      endcase
      if (e.status == ST_MISSING) n_missing++;
      owed.push_back(e);
    endfunction

    function void check_response(hkv_rsp_t a);
      hkv_rsp_t e;
      if (owed.size() == 0) begin
        $error("response with nothing outstanding: status %0d read_value %h",
               a.status, a.read_value);
        mismatches++;
        return;
      end
      e = owed.pop_front();
      n_checked++;
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        mismatches++;
      end
      if (a.read_value !== e.read_value) begin
        $error("read_value: expected %h, got %h", e.read_value, a.read_value);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  hkv_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  hkv_rsp_t rsp;

  hkv_shadow_table sb;
  bit          quiet = 1'b0;
  int unsigned rsp_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned hot_bkt [6];
  logic [KEY_W-1:0] key_pool [$];

  hashed_key_value_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Present one request after a random gap, hold it until accepted
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    int unsigned gap;
    hkv_req_t r;
    r.func = f;
    r.key = k;
    r.value = v;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.apply_request(r);
  endtask

  // Stop sending until every response has come back
  task automatic wait_all_answered();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Key that lands in one of the hot buckets
  function automatic logic [KEY_W-1:0] hot_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    k[BKT_W-1:0] = BKT_W'(hot_bkt[$urandom_range(0, 5)]);
    return k;
  endfunction

  // Response side: random stall count per response, counted while one waits
  always @(posedge clk) begin : rsp_side
    int unsigned n;
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_hold <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      sb.check_response(rsp);
      n = quiet ? 0 : $urandom_range(0, 4);
      rsp_hold <= n;
      rsp_stall <= (n != 0);
    end else if (rsp_valid && rsp_hold != 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_stall <= (rsp_hold > 1);
    end
  end

  // Watchdog: too long without any handshake means a hang
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0]  k;
    logic [VAL_W-1:0]  v;
    int unsigned       pick;

    sb = new();
    hot_bkt = '{0, BUCKETS_DEF - 1, 5, $urandom_range(0, BUCKETS_DEF - 1),
                $urandom_range(0, BUCKETS_DEF - 1), $urandom_range(0, BUCKETS_DEF - 1)};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table: get and delete miss
    send_request(OP_GET, 64'd0, 64'd0);
    send_request(OP_DEL, 64'd0, '1);
    // extreme keys and values
    send_request(OP_SET, 64'd0, 64'd0);
    send_request(OP_SET, '1, '1);
    send_request(OP_GET, '1, 64'd0);
    send_request(OP_SET, 64'd0, 64'hA5A5_5A5A_F00F_0FF0);
    send_request(OP_GET, 64'd0, '1);
    // fill bucket 5, then overflow it
    send_request(OP_SET, 64'd5, 64'h1111);
    send_request(OP_SET, 64'd1029, 64'h2222);
    send_request(OP_SET, 64'd2053, 64'h3333);
    send_request(OP_SET, 64'd3077, 64'h4444);
    send_request(OP_SET, 64'd4101, 64'h5555);
    // overwrite still works on a full bucket
    send_request(OP_SET, 64'd1029, 64'h6666);
    // free a middle way and refill it
    send_request(OP_DEL, 64'd1029, 64'd0);
    send_request(OP_SET, 64'd4101, 64'h7777);
    send_request(OP_GET, 64'd4101, 64'd0);
    send_request(OP_GET, 64'd2053, 64'd0);
    // delete of a key already gone, bucket not empty
    send_request(OP_DEL, 64'd1029, 64'd0);
    // unused operation code
    send_request(OP_UNUSED, 64'd5, '1);
    send_request(OP_DEL, 64'd0, 64'd0);
    send_request(OP_GET, 64'd0, 64'd0);
    wait_all_answered();

    // Random traffic over hot buckets, reusing stored keys for hits
    for (int i = 0; i < RANDOM_REQS; i++) begin
      quiet = (i >= 150 && i < 270);
      if (i == 300) wait_all_answered();
      pick = $urandom_range(0, 99);
      if (pick < 3) f = OP_UNUSED;
      else if (pick < 43) f = OP_SET;
      else if (pick < 78) f = OP_GET;
      else f = OP_DEL;
      pick = $urandom_range(0, 99);
      if (key_pool.size() != 0 && pick < 60)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (pick < 92) k = hot_key();
      else k = {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      if (pick == 0) v = '0;
      else if (pick == 1) v = '1;
      else v = {$urandom, $urandom};
      if (f == OP_SET) begin
        if (key_pool.size() < POOL_MAX) key_pool.push_back(k);
        else key_pool[$urandom_range(0, POOL_MAX - 1)] = k;
      end
      send_request(f, k, v);
    end
    quiet = 1'b0;

    wait_all_answered();
    repeat (20) @(posedge clk);
    if (sb.owed.size() != 0) begin
      $error("%0d responses never arrived", sb.owed.size());
      sb.mismatches++;
    end

    $display("checked %0d responses: %0d stores, %0d full buckets, %0d get hits,",
             sb.n_checked, sb.n_stored, sb.n_full, sb.n_found);
    $display("  %0d not-found results, over %0d hot buckets plus random keys",
             sb.n_missing, 6);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
